// ===== design/pkbc_pkg.sv =====
package pkbc_pkg;

  localparam int KEY_W  = 32;
  localparam int BASE_W = 64;
  localparam int OP_W   = 2;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [BASE_W-1:0] base_t;
  typedef logic [OP_W-1:0]   op_t;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_STORE  = 2'd1,
    OP_INVAL  = 2'd2
  } opcode_t;

  typedef struct packed {
    key_t  key;
    base_t first;
    base_t second;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

// ===== design/pkbc_if.sv =====
interface pkbc_req_if import pkbc_pkg::*; ();
  logic  valid;
  logic  ready;
  op_t   opcode;
  key_t  process_id;
  logic  want_first;
  logic  want_second;
  base_t first_base;
  base_t second_base;

  modport source (
    output valid, opcode, process_id, want_first, want_second, first_base, second_base,
    input  ready
  );
  modport sink (
    input  valid, opcode, process_id, want_first, want_second, first_base, second_base,
    output ready
  );
endinterface

interface pkbc_rsp_if import pkbc_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  found;
  base_t first_out;
  base_t second_out;

  modport source (
    output valid, found, first_out, second_out,
    input  ready
  );
  modport sink (
    input  valid, found, first_out, second_out,
    output ready
  );
endinterface

// ===== design/pkbc_ram.sv =====
module pkbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/pkbc_mod.sv =====
module pkbc_mod import pkbc_pkg::*; #(
  parameter int DIVISOR = 16,
  localparam int RW = (DIVISOR > 1) ? $clog2(DIVISOR) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  key_t          dividend,
  output logic          done,
  output logic [RW-1:0] rem
);

  // key mod DIVISOR by a reciprocal multiply; rem is valid once done is set again
  localparam int SH = $clog2(DIVISOR);
  localparam int MW = KEY_W + 1;
  localparam int PW = KEY_W + MW;
  localparam logic [PW-1:0] ONE_P = PW'(1);
  localparam logic [MW-1:0] RECIP = MW'((ONE_P << (KEY_W + SH)) / PW'(DIVISOR) + ONE_P);
  localparam key_t DIV_K = KEY_W'(DIVISOR);

  logic [1:0]    phase;
  key_t          num;
  logic [PW-1:0] prod;
  key_t          quo;
  key_t          back;

  assign quo  = KEY_W'(prod >> (KEY_W + SH));
  assign done = (phase == '0);
  assign rem  = back[RW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (start) begin
      phase <= 2'd2;
    end else if (!done) begin
      phase <= phase - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
    end
    prod <= PW'(num) * PW'(RECIP);
    back <= num - quo * DIV_K;
  end

endmodule

// ===== design/process_keyed_base_cache.sv =====
// The result is loaded into the output register once the scan and any remainder are done; the scan reads
// one slot per cycle from the slot RAM and stops at the first matching slot.
// A store that misses a full table uses the remainder unit, started on accept; FINISH waits for it.
// One request at a time; ready returns the cycle after the result is loaded into the output
// register, and that load waits while the output register holds a result not yet taken.
// Reset: synchronous; all slots read as empty right after reset through per-slot valid bits.
module process_keyed_base_cache import pkbc_pkg::*; #(
  parameter int SLOT_COUNT = 16
) (
  input logic         clk,
  input logic         rst,
  pkbc_req_if.sink    req,
  pkbc_rsp_if.source  rsp
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IW:0]   IDX_END  = (IW+1)'(SLOT_COUNT);
  localparam logic [IW:0]   LAST_W   = (IW+1)'(SLOT_COUNT - 1);
  localparam logic [IW-1:0] LAST_IDX = LAST_W[IW-1:0];

  state_t state, state_next;

  op_t   op;
  key_t  id;
  logic  want_a;
  logic  want_b;
  base_t base_a;
  base_t base_b;

  logic [IW:0]           idx;
  logic                  chk_vld;
  logic [IW-1:0]         chk_idx;
  logic                  hit;
  logic [IW-1:0]         hit_idx;
  slot_t                 hit_data;
  logic                  empty_found;
  logic [IW-1:0]         empty_idx;
  logic [SLOT_COUNT-1:0] valid;

  logic out_full;
  logic out_found;
  base_t out_first;
  base_t out_second;

  slot_t         rd;
  slot_t         eff;
  logic          match;
  logic          empty;
  logic          scan_end;
  logic          accept;
  logic          issue_en;
  logic          out_free;
  logic          mod_need;
  logic          mod_done;
  logic [IW-1:0] mod_rem;
  logic          fire;
  logic          we;
  logic [IW-1:0] waddr;
  slot_t         wdata;
  logic          lk;
  base_t         res_a;
  base_t         res_b;

  pkbc_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx[IW-1:0]),
    .rdata (rd)
  );

  pkbc_mod #(.DIVISOR(SLOT_COUNT)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (req.process_id),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign eff      = valid[chk_idx] ? rd : '0;
  assign match    = chk_vld && (eff.key == id);
  assign empty    = chk_vld && (eff.key == '0);
  assign scan_end = chk_vld && (match || (chk_idx == LAST_IDX));
  assign out_free = !out_full || rsp.ready;
  assign mod_need = (op == OP_STORE) && !hit && !empty_found;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_end) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (fire) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    issue_en  = 1'b0;
    fire      = 1'b0;
    case (state)
      ST_IDLE:   req.ready = 1'b1;
      ST_SCAN:   issue_en  = (idx != IDX_END) && !scan_end;
      ST_FINISH: fire      = out_free && (!mod_need || mod_done);
      default:   ;
    endcase
  end

  assign accept = req.valid && req.ready;

  always_comb begin
    wdata = '0;
    waddr = hit_idx;
    we    = fire && (op == OP_STORE);
    wdata.key = id;
    if (hit) begin
      wdata.first  = (base_a != '0) ? base_a : hit_data.first;
      wdata.second = (base_b != '0) ? base_b : hit_data.second;
    end else begin
      wdata.first  = base_a;
      wdata.second = base_b;
      waddr        = empty_found ? empty_idx : mod_rem;
    end
  end

  assign lk    = (op == OP_LOOKUP) && hit;
  assign res_a = (lk && want_a) ? hit_data.first  : '0;
  assign res_b = (lk && want_b) ? hit_data.second : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      chk_vld <= 1'b0;
      valid   <= '0;
    end else begin
      state   <= state_next;
      chk_vld <= issue_en;
      if (we) begin
        valid[waddr] <= 1'b1;
      end else if (fire && (op == OP_INVAL) && hit) begin
        valid[hit_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= idx[IW-1:0];
    if (accept) begin
      op          <= req.opcode;
      id          <= req.process_id;
      want_a      <= req.want_first;
      want_b      <= req.want_second;
      base_a      <= req.first_base;
      base_b      <= req.second_base;
      idx         <= '0;
      hit         <= 1'b0;
      empty_found <= 1'b0;
    end else begin
      if (issue_en) begin
        idx <= idx + 1'b1;
      end
      if (match) begin
        hit      <= 1'b1;
        hit_idx  <= chk_idx;
        hit_data <= eff;
      end
      if (empty && !empty_found) begin
        empty_found <= 1'b1;
        empty_idx   <= chk_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (fire) begin
      out_full <= 1'b1;
    end else if (rsp.ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_found  <= (res_a != '0) || (res_b != '0);
      out_first  <= res_a;
      out_second <= res_b;
    end
  end

  assign rsp.valid      = out_full;
  assign rsp.found      = out_found;
  assign rsp.first_out  = out_first;
  assign rsp.second_out = out_second;

endmodule

// ===== sim/tb_process_keyed_base_cache.sv =====
module tb_process_keyed_base_cache;
  import pkbc_pkg::*;

  localparam int CACHE_SLOTS = 16;
  localparam op_t OP_UNUSED = 2'd3;
  localparam int SINK_HOLD = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int POOL_SIZE = 20;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    op_t   op;
    key_t  id;
    logic  want_first;
    logic  want_second;
    base_t first_base;
    base_t second_base;
  } req_t;

  typedef struct packed {
    logic  found;
    base_t first_out;
    base_t second_out;
  } rsp_t;

  logic clk = 1'b0;
  logic rst;

  pkbc_req_if req_if ();
  pkbc_rsp_if rsp_if ();

  process_keyed_base_cache #(.SLOT_COUNT(CACHE_SLOTS)) dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  always #5 clk = ~clk;

  // shadow copy of the slot table
  key_t  shadow_key[CACHE_SLOTS];
  base_t shadow_first[CACHE_SLOTS];
  base_t shadow_second[CACHE_SLOTS];

  rsp_t expected_rsps[$];
  key_t key_pool[POOL_SIZE];

  int errors = 0;
  int stall_cycles = 0;
  int hold_token = 0;
  bit src_gaps_on = 1'b1;
  bit sink_gaps_on = 1'b1;

  function automatic void clear_shadow();
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      shadow_key[i] = '0;
      shadow_first[i] = '0;
      shadow_second[i] = '0;
    end
  endfunction

  // Applies one request to the shadow table and returns the result it yields.
  function automatic rsp_t predict_cache(req_t r);
    rsp_t res;
    int hit;
    int pick;
    res = '0;
    hit = -1;
    pick = -1;
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      if (hit < 0 && shadow_key[i] == r.id) hit = i;
    end
    case (r.op)
      OP_LOOKUP: begin
        if (hit >= 0) begin
          if (r.want_first) res.first_out = shadow_first[hit];
          if (r.want_second) res.second_out = shadow_second[hit];
          res.found = (res.first_out != '0) || (res.second_out != '0);
        end
      end
      OP_STORE: begin
        if (hit >= 0) begin
          if (r.first_base != '0) shadow_first[hit] = r.first_base;
          if (r.second_base != '0) shadow_second[hit] = r.second_base;
        end else begin
          for (int i = 0; i < CACHE_SLOTS; i++) begin
            if (pick < 0 && shadow_key[i] == '0) pick = i;
          end
          if (pick < 0) pick = int'(r.id % CACHE_SLOTS);
          shadow_key[pick] = r.id;
          shadow_first[pick] = r.first_base;
          shadow_second[pick] = r.second_base;
        end
      end
      OP_INVAL: begin
        if (hit >= 0) begin
          shadow_key[hit] = '0;
          shadow_first[hit] = '0;
          shadow_second[hit] = '0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int sender_gap();
    if (src_gaps_on && $urandom_range(0, 99) < 40) return pick_gap();
    return 0;
  endfunction

  function automatic req_t mk_req(op_t op, key_t id, logic wf, logic ws, base_t fb, base_t sb);
    req_t r;
    r.op = op;
    r.id = id;
    r.want_first = wf;
    r.want_second = ws;
    r.first_base = fb;
    r.second_base = sb;
    return r;
  endfunction

  function automatic base_t random_base();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return '0;
    if (r < 25) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic req_t random_request();
    req_t r;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 38) r.op = OP_LOOKUP;
    else if (sel < 80) r.op = OP_STORE;
    else r.op = OP_INVAL;
    sel = $urandom_range(0, 99);
    if (sel < 90) r.id = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    else if (sel < 94) r.id = '0;
    else r.id = $urandom;
    r.want_first = 1'($urandom_range(0, 1));
    r.want_second = 1'($urandom_range(0, 1));
    r.first_base = random_base();
    r.second_base = random_base();
    return r;
  endfunction

  function automatic void refill_key_pool();
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
  endfunction

  task automatic send_request(input req_t r, input int gap);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.opcode <= r.op;
    req_if.process_id <= r.id;
    req_if.want_first <= r.want_first;
    req_if.want_second <= r.want_second;
    req_if.first_base <= r.first_base;
    req_if.second_base <= r.second_base;
    do @(posedge clk); while (!req_if.ready);
    expected_rsps.push_back(predict_cache(r));
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (expected_rsps.size() != 0);
  endtask

  task automatic test_basic_ops();
    send_request(mk_req(OP_LOOKUP, '0, 1'b1, 1'b1, '0, '0), 0);
    send_request(mk_req(OP_LOOKUP, '1, 1'b1, 1'b1, '1, '1), 0);
    send_request(mk_req(OP_STORE, '1, 1'b0, 1'b0, '1, 64'd1), sender_gap());
    send_request(mk_req(OP_LOOKUP, '1, 1'b1, 1'b1, '0, '0), 0);
    send_request(mk_req(OP_LOOKUP, '1, 1'b0, 1'b0, '0, '0), sender_gap());
    send_request(mk_req(OP_LOOKUP, '1, 1'b1, 1'b0, '0, '0), 0);
    send_request(mk_req(OP_LOOKUP, '1, 1'b0, 1'b1, '0, '0), 0);
    // partial overwrite: zero first base keeps the old one
    send_request(mk_req(OP_STORE, '1, 1'b1, 1'b1, '0, 64'h8000_0000_0000_0000), 0);
    send_request(mk_req(OP_LOOKUP, '1, 1'b1, 1'b1, '0, '0), sender_gap());
    send_request(mk_req(OP_INVAL, 32'h1234_5678, 1'b0, 1'b0, '0, '0), 0);
    send_request(mk_req(OP_UNUSED, '1, 1'b1, 1'b1, 64'h5a5a, 64'ha5a5), 0);
    send_request(mk_req(OP_LOOKUP, '1, 1'b1, 1'b1, '0, '0), 0);
    send_request(mk_req(OP_INVAL, '1, 1'b1, 1'b1, '1, '1), sender_gap());
    send_request(mk_req(OP_LOOKUP, '1, 1'b1, 1'b1, '0, '0), 0);
  endtask

  task automatic test_key_zero();
    send_request(mk_req(OP_STORE, '0, 1'b0, 1'b0, 64'hdead_beef_0000_0001, '0), 0);
    send_request(mk_req(OP_LOOKUP, '0, 1'b1, 1'b1, '0, '0), 0);
    // miss allocates the first key-zero slot, dropping the bases left there
    send_request(mk_req(OP_STORE, 32'h1, 1'b0, 1'b0, '0, 64'h77), sender_gap());
    send_request(mk_req(OP_INVAL, '0, 1'b0, 1'b0, '0, '0), 0);
    send_request(mk_req(OP_LOOKUP, 32'h1, 1'b1, 1'b1, '0, '0), 0);
  endtask

  task automatic test_full_table();
    key_t fill_keys[CACHE_SLOTS];
    key_t evict_key;
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      fill_keys[i] = $urandom | 32'h100;
      send_request(mk_req(OP_STORE, fill_keys[i], 1'b0, 1'b0, random_base(), {$urandom, $urandom}),
                   sender_gap());
    end
    // table is full now; a miss replaces slot id mod slot count
    evict_key = {28'($urandom_range(1, 32'h0fff_ffff)), 4'd7};
    send_request(mk_req(OP_STORE, evict_key, 1'b0, 1'b0, {$urandom, $urandom}, '0), 0);
    send_request(mk_req(OP_LOOKUP, evict_key, 1'b1, 1'b1, '0, '0), 0);
    send_request(mk_req(OP_LOOKUP, fill_keys[7], 1'b1, 1'b1, '0, '0), 0);
    send_request(mk_req(OP_LOOKUP, fill_keys[3], 1'b1, 1'b1, '0, '0), 0);
  endtask

  task automatic test_output_stall();
    wait_drained();
    hold_token++;
    for (int i = 0; i < 12; i++) send_request(random_request(), 0);
  endtask

  task automatic test_random_traffic(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        src_gaps_on = $urandom_range(0, 3) != 0;
        sink_gaps_on = $urandom_range(0, 3) != 0;
      end
      if (n % 200 == 0) refill_key_pool();
      if (n == count / 2) wait_drained();
      send_request(random_request(), sender_gap());
    end
  endtask

  // result sink: random gaps plus requested long holds
  initial begin
    int gap;
    int hold_taken;
    gap = 0;
    hold_taken = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_token != hold_taken) begin
        hold_taken = hold_token;
        gap = SINK_HOLD;
      end
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        gap--;
      end else begin
        rsp_if.ready <= 1'b1;
        if (sink_gaps_on && $urandom_range(0, 99) < 25) gap = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    rsp_t want_rsp;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected result beat: found %0b first_out %h second_out %h",
               rsp_if.found, rsp_if.first_out, rsp_if.second_out);
        errors++;
      end else begin
        want_rsp = expected_rsps.pop_front();
        if (rsp_if.found !== want_rsp.found) begin
          $error("found: expected %0b, got %0b", want_rsp.found, rsp_if.found);
          errors++;
        end
        if (rsp_if.first_out !== want_rsp.first_out) begin
          $error("first_out: expected %h, got %h", want_rsp.first_out, rsp_if.first_out);
          errors++;
        end
        if (rsp_if.second_out !== want_rsp.second_out) begin
          $error("second_out: expected %h, got %h", want_rsp.second_out, rsp_if.second_out);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.opcode <= OP_LOOKUP;
    req_if.process_id <= '0;
    req_if.want_first <= 1'b0;
    req_if.want_second <= 1'b0;
    req_if.first_base <= '0;
    req_if.second_base <= '0;
    clear_shadow();
    refill_key_pool();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_ops();
    test_key_zero();
    test_full_table();
    test_output_stall();
    test_random_traffic(740);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/pkbc_pkg.sv
design/pkbc_if.sv
design/pkbc_ram.sv
design/pkbc_mod.sv
design/process_keyed_base_cache.sv
sim/tb_process_keyed_base_cache.sv
